[hdl/bdq_pkg.sv]
// bdq_pkg: shared types and codes for the bounded double-ended queue
// request and result beat layouts, opcodes, status codes and sequencer states
// no dependencies
package bdq_pkg;

  localparam int OPCODE_W = 3;
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CONTAINS   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SIZE       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [FIELD_W-1:0]  data_in;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  data_out;
    logic                found;
    logic [COUNT_W-1:0]  item_count;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_DONE
  } seq_state_t;

endpackage

[hdl/bdq_if.sv]
// bdq_req_if, bdq_rsp_if: valid/ready channels for request and result beats
// depends on bdq_pkg
interface bdq_req_if;
  logic          valid;
  logic          ready;
  bdq_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bdq_rsp_if;
  logic          valid;
  logic          ready;
  bdq_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/bounded_deque_with_search.sv]
// bounded_deque_with_search: top level, ring, sequencer and result register
// depends on bdq_pkg, bdq_if, bdq_ring, bdq_seq
//
//   channel  dir  beat fields
//   req      in   opcode[2:0], data_in[31:0]
//   rsp      out  data_out[31:0], found, item_count[4:0], status[1:0]
//
// push, size, spare and failed ops: S_IDLE to S_DONE, then the result register
// pop: through S_READ as well, for the registered read of the ring
// contains: through S_SEARCH until a hit or the last entry, one stored entry per cycle through one comparator
// req is ready again the cycle after the result is registered; a new result waits in S_DONE while rsp stalls
// rst is synchronous and empties the queue; ring contents are not cleared
// req is taken again while a result still waits on a stalled rsp
module bounded_deque_with_search #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  bdq_req_if.sink     req,
  bdq_rsp_if.source   rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  done;
  logic                  out_free;
  bdq_pkg::rsp_t         result;
  logic                  out_valid;
  bdq_pkg::rsp_t         out_data;

  assign out_free    = !out_valid || rsp.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  bdq_ring #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bdq_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_payload (req.payload),
    .req_ready   (req.ready),
    .out_free    (out_free),
    .done        (done),
    .result      (result),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data <= result;
    end
  end

endmodule

[hdl/bdq_ring.sv]
// bdq_ring: ring storage, one write port and one registered read port
// no package dependencies
module bdq_ring #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/bdq_seq.sv]
// bdq_seq: sequencer with ring pointers and the single shared comparator
// depends on bdq_pkg; drives the ports of bdq_ring
module bdq_seq #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  bdq_pkg::req_t         req_payload,
  output logic                  req_ready,
  input  logic                  out_free,
  output logic                  done,
  output bdq_pkg::rsp_t         result,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [DATA_WIDTH-1:0] rd_data
);

  bdq_pkg::seq_state_t state, state_next;
  logic [AW-1:0]         front, front_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         idx, idx_next;
  logic [DATA_WIDTH-1:0] val, val_next;
  bdq_pkg::rsp_t         res, res_next;

  logic                  accept;
  logic                  empty;
  logic                  full;
  logic                  is_pop;
  logic                  is_contains;
  logic                  hit;
  logic                  last;
  logic [CW-1:0]         idx_inc;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign req_ready   = (state == bdq_pkg::S_IDLE);
  assign accept      = req_valid && req_ready;
  assign empty       = (count == '0);
  assign full        = (count == CW'(DEPTH));
  assign is_pop      = (req_payload.opcode == bdq_pkg::OP_POP_FRONT) ||
                       (req_payload.opcode == bdq_pkg::OP_POP_BACK);
  assign is_contains = (req_payload.opcode == bdq_pkg::OP_CONTAINS);
  assign hit         = (rd_data == val);
  assign idx_inc     = idx + CW'(1);
  assign last        = (idx_inc == count);
  assign done        = (state == bdq_pkg::S_DONE) && out_free;

  always_comb begin
    result            = res;
    result.item_count = bdq_pkg::COUNT_W'(count);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          if (is_pop && !empty) begin
            state_next = bdq_pkg::S_READ;
          end else if (is_contains && !empty) begin
            state_next = bdq_pkg::S_SEARCH;
          end else begin
            state_next = bdq_pkg::S_DONE;
          end
        end
      end
      bdq_pkg::S_READ: begin
        state_next = bdq_pkg::S_DONE;
      end
      bdq_pkg::S_SEARCH: begin
        if (hit || last) begin
          state_next = bdq_pkg::S_DONE;
        end
      end
      bdq_pkg::S_DONE: begin
        if (out_free) begin
          state_next = bdq_pkg::S_IDLE;
        end
      end
      default: state_next = bdq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    front_next = front;
    count_next = count;
    idx_next   = idx;
    val_next   = val;
    res_next   = res;
    wr_en      = 1'b0;
    wr_addr    = front;
    wr_data    = DATA_WIDTH'(req_payload.data_in);
    rd_en      = 1'b0;
    rd_addr    = front;
    unique case (state)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          val_next = DATA_WIDTH'(req_payload.data_in);
          idx_next = '0;
          res_next = '{data_out: '0, found: 1'b0, item_count: '0, status: bdq_pkg::ST_OK};
          unique case (req_payload.opcode)
            bdq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res_next.status = bdq_pkg::ST_FULL;
              end else begin
                front_next = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
                wr_en      = 1'b1;
                wr_addr    = front_next;
                count_next = count + CW'(1);
              end
            end
            bdq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res_next.status = bdq_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = wrap(front, count);
                count_next = count + CW'(1);
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res_next.status = bdq_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = front;
                front_next = wrap(front, CW'(1));
                count_next = count - CW'(1);
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_next.status = bdq_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = wrap(front, count - CW'(1));
                count_next = count - CW'(1);
              end
            end
            bdq_pkg::OP_CONTAINS: begin
              if (!empty) begin
                rd_en   = 1'b1;
                rd_addr = front;
              end
            end
            default: ;
          endcase
        end
      end
      bdq_pkg::S_READ: begin
        res_next.data_out = bdq_pkg::FIELD_W'(rd_data);
      end
      bdq_pkg::S_SEARCH: begin
        if (hit) begin
          res_next.found = 1'b1;
        end else if (!last) begin
          idx_next = idx_inc;
          rd_en    = 1'b1;
          rd_addr  = wrap(front, idx_inc);
        end
      end
      bdq_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    val <= val_next;
    res <= res_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_write_search: assert property (@(posedge clk) disable iff (rst)
    (state == bdq_pkg::S_SEARCH) |-> !wr_en)
    else $error("ring written during search");

  a_read_then_done: assert property (@(posedge clk) disable iff (rst)
    (state == bdq_pkg::S_READ) |=> (state == bdq_pkg::S_DONE))
    else $error("pop read did not complete");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == bdq_pkg::S_DONE && res.status == bdq_pkg::ST_FULL) |-> full)
    else $error("full status with room left");

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == bdq_pkg::S_SEARCH) |-> (!empty && idx < count))
    else $error("search index out of range");
`endif

endmodule
